/* hdl/fbpa_pkg.sv */
// ----------------------------------------------------------------------------
// fbpa_pkg: shared definitions of the fixed block pool allocator
// Sizes, command and status codes, register indexes, FSM states and the
// pool geometry that is derived from the configuration registers.
// ----------------------------------------------------------------------------
`default_nettype none

package fbpa_pkg;

	// Sizes
	localparam int ADDR_W      = 32;
	localparam int MAX_PAGES   = 16;
	localparam int STACK_DEPTH = 1024;
	localparam int STACK_AW    = $clog2(STACK_DEPTH);
	localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
	localparam int PAGE_W      = $clog2(MAX_PAGES + 1);
	localparam int REQ_W       = 16;
	localparam int ALIGN_W     = 13;
	localparam int BPP_W       = 13;
	localparam int BS_W        = 17;
	localparam int PSIZE_W     = BS_W + BPP_W;
	localparam int USED_W      = ADDR_W + 1;
	localparam int TOTAL_W     = 48;
	localparam int STAT_W      = 32;
	localparam int CFG_IDX_W   = 8;
	localparam int CFG_DATA_W  = 32;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_REQ_SIZE = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] CFG_ALIGN    = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] CFG_BPP      = CFG_IDX_W'(2);
	localparam logic [CFG_IDX_W-1:0] CFG_BASE     = CFG_IDX_W'(3);

	// Commands
	typedef enum logic [1:0] {
		CMD_ALLOC = 2'd0,
		CMD_FREE  = 2'd1,
		CMD_QUERY = 2'd2,
		CMD_NOP   = 2'd3
	} cmd_t;

	// Result status
	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_OOM     = 2'd1,
		ST_FULL    = 2'd2,
		ST_NULL    = 2'd3
	} status_t;

	// Item FSM
	typedef enum logic [0:0] {
		S_IDLE = 1'b0,
		S_EXEC = 1'b1
	} state_t;

	// Geometry derived from the configuration registers
	typedef struct packed {
		logic [BS_W-1:0]    bs;      // effective block size
		logic [BPP_W-1:0]   bpp;     // effective blocks per page
		logic [PSIZE_W-1:0] psize;   // page size
		logic [PSIZE_W-1:0] pofs;    // offset of the highest block in a page
		logic [ADDR_W-1:0]  rstart;  // aligned region start
		logic [USED_W-1:0]  room1;   // bytes from region start to top of space
	} geom_t;

	localparam geom_t GEOM_RST = '{
		bs:     BS_W'(16),
		bpp:    BPP_W'(1),
		psize:  PSIZE_W'(16),
		pofs:   '0,
		rstart: '0,
		room1:  {1'b1, {ADDR_W{1'b0}}}
	};

	// Free stack control
	typedef struct packed {
		logic clear;
		logic rd_en;
		logic push;
		logic pop;
	} stk_ctl_t;

endpackage

`default_nettype wire

/* hdl/fbpa_cfg.sv */
// ----------------------------------------------------------------------------
// fbpa_cfg: configuration registers and pool geometry
// Holds the four registers and derives block size, page size and the aligned
// region start on every write, so the item path sees ready-made values.
// ----------------------------------------------------------------------------
`default_nettype none

module fbpa_cfg
	import fbpa_pkg::*;
(
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   cfg_valid,
	output logic                  cfg_ready,
	input  wire  [CFG_IDX_W-1:0]  cfg_index,
	input  wire  [CFG_DATA_W-1:0] cfg_data,
	output geom_t                 geom,
	output logic                  pool_clear
);

	logic [REQ_W-1:0]   req_q, req_nx;
	logic [ALIGN_W-1:0] align_q, align_nx;
	logic [BPP_W-1:0]   bpp_q, bpp_nx;
	logic [ADDR_W-1:0]  base_q, base_nx;
	logic               idx_ok;
	geom_t              geom_q, geom_nx;

	logic [3:0]         a_log;
	logic [ALIGN_W:0]   amask;
	logic [BS_W-1:0]    s_min;
	logic [BS_W-1:0]    s_sum;
	logic [ADDR_W:0]    rs_sum;

	// Writes are always taken
	assign cfg_ready = 1'b1;

	// Register decode, next values
	always_comb begin
		req_nx   = req_q;
		align_nx = align_q;
		bpp_nx   = bpp_q;
		base_nx  = base_q;
		idx_ok   = 1'b1;
		unique case (cfg_index)
			CFG_REQ_SIZE: req_nx   = cfg_data[REQ_W-1:0];
			CFG_ALIGN:    align_nx = cfg_data[ALIGN_W-1:0];
			CFG_BPP:      bpp_nx   = cfg_data[BPP_W-1:0];
			CFG_BASE:     base_nx  = cfg_data[ADDR_W-1:0];
			default:      idx_ok   = 1'b0;
		endcase
	end

	assign pool_clear = cfg_valid && idx_ok;

	// Geometry of the next register set
	always_comb begin
		// smallest power of two >= alignment, at least 16
		a_log = 4'd13;
		for (int k = 13; k >= 4; k--) begin
			if (((ALIGN_W+1)'(1) << k) >= {1'b0, align_nx})
				a_log = 4'(k);
		end
		amask = (ALIGN_W+1)'(((ALIGN_W+1)'(1) << a_log) - (ALIGN_W+1)'(1));

		s_min = (req_nx < REQ_W'(8)) ? BS_W'(8) : {1'b0, req_nx};
		s_sum = s_min + BS_W'(amask);

		geom_nx.bs     = s_sum & ~BS_W'(amask);
		geom_nx.bpp    = (bpp_nx == '0) ? BPP_W'(1) : bpp_nx;
		geom_nx.psize  = {{BPP_W{1'b0}}, geom_nx.bs} * {{BS_W{1'b0}}, geom_nx.bpp};
		geom_nx.pofs   = geom_nx.psize - {{BPP_W{1'b0}}, geom_nx.bs};

		rs_sum         = {1'b0, base_nx} + (ADDR_W+1)'(amask);
		geom_nx.rstart = rs_sum[ADDR_W-1:0] & ~ADDR_W'(amask);
		geom_nx.room1  = {1'b1, {ADDR_W{1'b0}}} - {1'b0, geom_nx.rstart};
	end

	// Register file and derived values
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_q   <= '0;
			align_q <= ALIGN_W'(16);
			bpp_q   <= BPP_W'(1);
			base_q  <= '0;
			geom_q  <= GEOM_RST;
		end else if (pool_clear) begin
			req_q   <= req_nx;
			align_q <= align_nx;
			bpp_q   <= bpp_nx;
			base_q  <= base_nx;
			geom_q  <= geom_nx;
		end
	end

	assign geom = geom_q;

endmodule

`default_nettype wire

/* hdl/fbpa_stack.sv */
// ----------------------------------------------------------------------------
// fbpa_stack: LIFO free stack
// Synchronous single-port style memory with a registered read of the top
// entry, plus the fill count. Entries above the count are never read.
// ----------------------------------------------------------------------------
`default_nettype none

module fbpa_stack
	import fbpa_pkg::*;
(
	input  wire                clk,
	input  wire                arst_n,
	input  stk_ctl_t           ctl,
	input  wire  [ADDR_W-1:0]  push_data,
	output logic [CNT_W-1:0]   count,
	output logic [ADDR_W-1:0]  top_data
);

	logic [ADDR_W-1:0] mem [STACK_DEPTH];
	logic [CNT_W-1:0]  count_q;
	logic [CNT_W-1:0]  count_m1;
	logic [ADDR_W-1:0] rd_data_q;

	assign count_m1 = count_q - CNT_W'(1);

	// Push writes at the count, read fetches the entry below it
	always_ff @(posedge clk) begin
		if (ctl.push)
			mem[count_q[STACK_AW-1:0]] <= push_data;
		if (ctl.rd_en)
			rd_data_q <= mem[count_m1[STACK_AW-1:0]];
	end

	// Fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (ctl.clear) begin
			count_q <= '0;
		end else if (ctl.push) begin
			count_q <= count_q + CNT_W'(1);
		end else if (ctl.pop) begin
			count_q <= count_m1;
		end
	end

	assign count    = count_q;
	assign top_data = rd_data_q;

endmodule

`default_nettype wire

/* hdl/fixed_block_pool_allocator.sv */
// ----------------------------------------------------------------------------
// fixed_block_pool_allocator: fixed-size block pool with a LIFO free stack
// Each accepted item is captured with the registered read of the free stack
//   top, executed in the execute state, and its result registered and strobed by done.
// A new item is not taken before the last one has executed, as set by the
//   synchronous read of the free stack memory; busy is high in the execute cycle.
// Results cannot be stalled by the receiver. Reset clears all counters and
//   loads the register defaults; stack memory contents stay undefined.
// ----------------------------------------------------------------------------
`default_nettype none

module fixed_block_pool_allocator
	import fbpa_pkg::*;
(
	input  wire                    clk,
	input  wire                    arst_n,
	// item in
	input  wire                    start,
	output logic                   busy,
	input  wire  [1:0]             command,
	input  wire  [ADDR_W-1:0]      block_address,
	// result out
	output logic                   done,
	output logic [ADDR_W-1:0]      result_address,
	output logic [1:0]             status,
	output logic                   is_contained,
	output logic [STAT_W-1:0]      current_bytes,
	output logic [STAT_W-1:0]      peak_bytes,
	output logic [TOTAL_W-1:0]     total_bytes,
	output logic [STAT_W-1:0]      allocation_count,
	output logic [STAT_W-1:0]      free_count,
	// configuration
	input  wire                    cfg_valid,
	output logic                   cfg_ready,
	input  wire  [CFG_IDX_W-1:0]   cfg_index,
	input  wire  [CFG_DATA_W-1:0]  cfg_data
);

	state_t             state_q, state_nx;
	logic               accept;
	logic               exec;
	geom_t              geom;
	logic               pool_clear;
	stk_ctl_t           stk_ctl;
	logic [CNT_W-1:0]   stk_count;
	logic [ADDR_W-1:0]  stk_top;

	// latched item
	cmd_t               cmd_q;
	logic [ADDR_W-1:0]  addr_q;

	// pool state
	logic [BPP_W-1:0]   fresh_rem_q, fresh_rem_nx;
	logic [ADDR_W-1:0]  fresh_addr_q, fresh_addr_nx;
	logic [PAGE_W-1:0]  pages_q, pages_nx;
	logic [USED_W-1:0]  used_q, used_nx;
	logic [STAT_W-1:0]  bytes_now_q, bytes_now_nx;
	logic [STAT_W-1:0]  bytes_peak_q, bytes_peak_nx;
	logic [TOTAL_W-1:0] bytes_total_q, bytes_total_nx;
	logic [STAT_W-1:0]  allocs_q, allocs_nx;
	logic [STAT_W-1:0]  frees_q, frees_nx;

	// result
	logic               done_q;
	logic [ADDR_W-1:0]  res_addr_q, res_addr_nx;
	status_t            status_q, status_nx;
	logic               cont_q, cont_nx;

	// datapath temporaries
	logic               push, pop, alloc_ok;
	logic [ADDR_W-1:0]  region_top;
	logic [ADDR_W-1:0]  new_page_addr;
	logic [USED_W:0]    used_plus;
	logic [STAT_W:0]    now_sum;
	logic [ADDR_W-1:0]  q_off;

	// Configuration registers
	fbpa_cfg u_cfg (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.geom       (geom),
		.pool_clear (pool_clear)
	);

	// Free stack
	assign stk_ctl.clear = pool_clear;
	assign stk_ctl.rd_en = accept;
	assign stk_ctl.push  = exec && push && !pool_clear;
	assign stk_ctl.pop   = exec && pop && !pool_clear;

	fbpa_stack u_stack (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (stk_ctl),
		.push_data (addr_q),
		.count     (stk_count),
		.top_data  (stk_top)
	);

	// FSM: next state
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			S_IDLE: if (accept) state_nx = S_EXEC;
			S_EXEC: state_nx = S_IDLE;
			default: state_nx = S_IDLE;
		endcase
	end

	// FSM: outputs
	always_comb begin
		busy = (state_q == S_EXEC);
		exec = (state_q == S_EXEC);
	end

	assign accept = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_nx;
	end

	// Item capture
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q  <= cmd_t'(command);
			addr_q <= block_address;
		end
	end

	// Common arithmetic
	assign region_top    = geom.rstart + used_q[ADDR_W-1:0];
	assign new_page_addr = region_top + ADDR_W'(geom.pofs);
	assign used_plus     = {1'b0, used_q} + (USED_W+1)'(geom.psize);
	assign now_sum       = {1'b0, bytes_now_q} + (STAT_W+1)'(geom.bs);
	assign q_off         = addr_q - geom.rstart;

	// Execute one item
	always_comb begin
		fresh_rem_nx   = fresh_rem_q;
		fresh_addr_nx  = fresh_addr_q;
		pages_nx       = pages_q;
		used_nx        = used_q;
		bytes_now_nx   = bytes_now_q;
		bytes_peak_nx  = bytes_peak_q;
		bytes_total_nx = bytes_total_q;
		allocs_nx      = allocs_q;
		frees_nx       = frees_q;
		res_addr_nx    = '0;
		status_nx      = ST_OK;
		cont_nx        = 1'b0;
		push           = 1'b0;
		pop            = 1'b0;
		alloc_ok       = 1'b0;

		case (cmd_q)
			CMD_ALLOC: begin
				if (stk_count != '0) begin
					// reuse a freed block
					pop         = 1'b1;
					res_addr_nx = stk_top;
					alloc_ok    = 1'b1;
				end else if (fresh_rem_q != '0) begin
					// next fresh block of the current page
					res_addr_nx   = fresh_addr_q;
					fresh_rem_nx  = fresh_rem_q - BPP_W'(1);
					fresh_addr_nx = fresh_addr_q - ADDR_W'(geom.bs);
					alloc_ok      = 1'b1;
				end else if (pages_q < PAGE_W'(MAX_PAGES) &&
						used_plus <= (USED_W+1)'(geom.room1)) begin
					// open a page, hand out its highest block
					res_addr_nx   = new_page_addr;
					fresh_rem_nx  = geom.bpp - BPP_W'(1);
					fresh_addr_nx = new_page_addr - ADDR_W'(geom.bs);
					used_nx       = used_plus[USED_W-1:0];
					pages_nx      = pages_q + PAGE_W'(1);
					alloc_ok      = 1'b1;
				end else begin
					status_nx = ST_OOM;
				end
				if (alloc_ok) begin
					bytes_now_nx   = now_sum[STAT_W] ? '1 : now_sum[STAT_W-1:0];
					if (bytes_now_nx > bytes_peak_q)
						bytes_peak_nx = bytes_now_nx;
					bytes_total_nx = bytes_total_q + TOTAL_W'(geom.bs);
					allocs_nx      = allocs_q + STAT_W'(1);
				end
			end
			CMD_FREE: begin
				if (addr_q == '0) begin
					status_nx = ST_NULL;
				end else if (stk_count >= CNT_W'(STACK_DEPTH)) begin
					status_nx = ST_FULL;
				end else begin
					push         = 1'b1;
					bytes_now_nx = (STAT_W'(geom.bs) <= bytes_now_q) ?
						bytes_now_q - STAT_W'(geom.bs) : '0;
					frees_nx     = frees_q + STAT_W'(1);
				end
			end
			CMD_QUERY: begin
				cont_nx = (addr_q != '0) && (pages_q != '0) &&
					(addr_q >= geom.rstart) && ({1'b0, q_off} < used_q);
			end
			default: begin
			end
		endcase
	end

	// Pool state and statistics
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fresh_rem_q   <= '0;
			fresh_addr_q  <= '0;
			pages_q       <= '0;
			used_q        <= '0;
			bytes_now_q   <= '0;
			bytes_peak_q  <= '0;
			bytes_total_q <= '0;
			allocs_q      <= '0;
			frees_q       <= '0;
		end else if (pool_clear) begin
			fresh_rem_q   <= '0;
			fresh_addr_q  <= '0;
			pages_q       <= '0;
			used_q        <= '0;
			bytes_now_q   <= '0;
			bytes_peak_q  <= '0;
			bytes_total_q <= '0;
			allocs_q      <= '0;
			frees_q       <= '0;
		end else if (exec) begin
			fresh_rem_q   <= fresh_rem_nx;
			fresh_addr_q  <= fresh_addr_nx;
			pages_q       <= pages_nx;
			used_q        <= used_nx;
			bytes_now_q   <= bytes_now_nx;
			bytes_peak_q  <= bytes_peak_nx;
			bytes_total_q <= bytes_total_nx;
			allocs_q      <= allocs_nx;
			frees_q       <= frees_nx;
		end
	end

	// Result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			done_q <= 1'b0;
		else
			done_q <= exec;
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (exec) begin
			res_addr_q <= res_addr_nx;
			status_q   <= status_nx;
			cont_q     <= cont_nx;
		end
	end

	assign done             = done_q;
	assign result_address   = res_addr_q;
	assign status           = status_q;
	assign is_contained     = cont_q;
	assign current_bytes    = bytes_now_q;
	assign peak_bytes       = bytes_peak_q;
	assign total_bytes      = bytes_total_q;
	assign allocation_count = allocs_q;
	assign free_count       = frees_q;

endmodule

`default_nettype wire

/* hdl/fbpa_checker.sv */
// ----------------------------------------------------------------------------
// fbpa_checker: port-level checks of the fixed block pool allocator
// Watches item timing and result consistency; bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module fbpa_checker
	import fbpa_pkg::*;
(
	input wire                clk,
	input wire                arst_n,
	input wire                start,
	input wire                busy,
	input wire                done,
	input wire [ADDR_W-1:0]   result_address,
	input wire [1:0]          status,
	input wire                is_contained,
	input wire [STAT_W-1:0]   current_bytes,
	input wire [STAT_W-1:0]   peak_bytes
);

	// An accepted item executes next cycle and strobes the cycle after
	a_item_timing: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy ##1 done)
		else $error("item result not strobed two cycles after accept");

	// A new item is not taken while one executes, so results never come back to back
	a_no_double_done: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobed in consecutive cycles");

	// A failed item hands out no address and no containment
	a_fail_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status != ST_OK) |-> (result_address == '0 && !is_contained))
		else $error("failed item returned an address or a hit");

	// Peak never trails the current byte count
	a_peak: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (peak_bytes >= current_bytes))
		else $error("peak bytes below current bytes");

endmodule

bind fixed_block_pool_allocator fbpa_checker u_fbpa_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.start          (start),
	.busy           (busy),
	.done           (done),
	.result_address (result_address),
	.status         (status),
	.is_contained   (is_contained),
	.current_bytes  (current_bytes),
	.peak_bytes     (peak_bytes)
);

`default_nettype wire

/* tb/fbpa_tb_pkg.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// fbpa_tb_pkg: result prediction and checking for the block pool allocator
// Keeps a private copy of the registers and of the pool (free stack, fresh
// page pointer, page count, statistics). Each accepted item is predicted at
// once, and results from the block are compared in order, field by field.
// ----------------------------------------------------------------------------
package fbpa_tb_pkg;
	import fbpa_pkg::*;

	localparam longint unsigned ADDR_SPACE_MASK = 64'hFFFF_FFFF;

	// One result as seen on the output ports
	typedef struct {
		logic [ADDR_W-1:0]  addr;
		logic [1:0]         status;
		logic               contained;
		logic [STAT_W-1:0]  cur_bytes;
		logic [STAT_W-1:0]  peak;
		logic [TOTAL_W-1:0] total;
		logic [STAT_W-1:0]  allocs;
		logic [STAT_W-1:0]  frees;
	} pool_result_t;

	class pool_scoreboard;
		// register copies
		logic [REQ_W-1:0]   req_size;
		logic [ALIGN_W-1:0] align_reg;
		logic [BPP_W-1:0]   bpp_reg;
		logic [ADDR_W-1:0]  base_reg;
		// pool state
		logic [ADDR_W-1:0]  freed[STACK_DEPTH];
		int unsigned        freed_cnt;
		longint unsigned    fresh_left, fresh_addr, pages;
		longint unsigned    region_top, region_start, region_used;
		logic [STAT_W-1:0]  bytes_now, bytes_peak, allocs, frees;
		logic [TOTAL_W-1:0] bytes_total;
		// results still owed by the block
		pool_result_t       expected_results[$];
		int                 errors, checked, contained_seen;
		int                 status_seen[4];

		function new();
			req_size = '0;
			align_reg = ALIGN_W'(16);
			bpp_reg = BPP_W'(1);
			base_reg = '0;
			errors = 0;
			checked = 0;
			contained_seen = 0;
			foreach (status_seen[i]) status_seen[i] = 0;
			clear_pool();
		endfunction

		// alignment rounds up to a power of two, never below 16
		function longint unsigned align_bytes();
			longint unsigned p;
			p = 16;
			while (p < align_reg) p = p << 1;
			return p;
		endfunction

		function longint unsigned block_bytes();
			longint unsigned a, s;
			a = align_bytes();
			s = (req_size < 8) ? 8 : req_size;
			return (s + a - 1) & ~(a - 1);
		endfunction

		function longint unsigned page_blocks();
			return (bpp_reg == 0) ? 1 : bpp_reg;
		endfunction

		function void clear_pool();
			longint unsigned a;
			a = align_bytes();
			freed_cnt = 0;
			fresh_left = 0;
			fresh_addr = 0;
			pages = 0;
			region_start = ((longint'(base_reg) + a - 1) & ~(a - 1)) & ADDR_SPACE_MASK;
			region_top = region_start;
			region_used = 0;
			bytes_now = '0;
			bytes_peak = '0;
			bytes_total = '0;
			allocs = '0;
			frees = '0;
		endfunction

		// a write to any of the four registers empties the pool
		function void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				CFG_REQ_SIZE: req_size = data[REQ_W-1:0];
				CFG_ALIGN:    align_reg = data[ALIGN_W-1:0];
				CFG_BPP:      bpp_reg = data[BPP_W-1:0];
				CFG_BASE:     base_reg = data[ADDR_W-1:0];
				default:      return;
			endcase
			clear_pool();
		endfunction

		// carve the next page; fails at the page limit or the top of the space
		function bit open_page();
			longint unsigned bs, bpp, psize, room;
			bs = block_bytes();
			bpp = page_blocks();
			psize = bs * bpp;
			room = ADDR_SPACE_MASK - region_start;
			if (pages >= MAX_PAGES) return 1'b0;
			if (region_used > room || psize - 1 > room - region_used) return 1'b0;
			fresh_addr = (region_top + (bpp - 1) * bs) & ADDR_SPACE_MASK;
			fresh_left = bpp;
			region_used += psize;
			region_top = (region_top + psize) & ADDR_SPACE_MASK;
			pages++;
			return 1'b1;
		endfunction

		function pool_result_t predict_result(cmd_t c, logic [ADDR_W-1:0] a);
			pool_result_t r;
			longint unsigned bs;
			logic [STAT_W:0] sum;
			bit ok;
			bs = block_bytes();
			r.addr = '0;
			r.status = ST_OK;
			r.contained = 1'b0;
			case (c)
				CMD_ALLOC: begin
					ok = 1'b1;
					if (freed_cnt > 0) begin
						freed_cnt--;
						r.addr = freed[freed_cnt];
					end else begin
						if (fresh_left == 0) ok = open_page();
						if (ok) begin
							r.addr = fresh_addr[ADDR_W-1:0];
							fresh_left--;
							fresh_addr = (fresh_addr - bs) & ADDR_SPACE_MASK;
						end
					end
					if (ok) begin
						// current bytes saturate, the total wraps
						sum = {1'b0, bytes_now} + (STAT_W+1)'(bs);
						bytes_now = sum[STAT_W] ? '1 : sum[STAT_W-1:0];
						if (bytes_now > bytes_peak) bytes_peak = bytes_now;
						bytes_total = bytes_total + TOTAL_W'(bs);
						allocs = allocs + 1'b1;
					end else begin
						r.status = ST_OOM;
						r.addr = '0;
					end
				end
				CMD_FREE: begin
					if (a == '0) begin
						r.status = ST_NULL;
					end else if (freed_cnt >= STACK_DEPTH) begin
						r.status = ST_FULL;
					end else begin
						// not checked against the pages; bytes floor at zero
						freed[freed_cnt] = a;
						freed_cnt++;
						bytes_now = (bs <= bytes_now) ? bytes_now - STAT_W'(bs) : '0;
						frees = frees + 1'b1;
					end
				end
				CMD_QUERY: begin
					r.contained = (a != '0) && (pages > 0) && (a >= region_start) &&
						(a - region_start < region_used);
				end
				default: ;
			endcase
			r.cur_bytes = bytes_now;
			r.peak = bytes_peak;
			r.total = bytes_total;
			r.allocs = allocs;
			r.frees = frees;
			expected_results = {expected_results, r};
			return r;
		endfunction

		function void field_check(string name, logic [TOTAL_W-1:0] want,
				logic [TOTAL_W-1:0] got);
			if (got !== want) begin
				$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
				errors++;
			end
		endfunction

		function void check_result(pool_result_t got);
			pool_result_t want;
			if (expected_results.size() == 0) begin
				$error("result strobed with no item outstanding");
				errors++;
				return;
			end
			want = expected_results.pop_front();
			checked++;
			status_seen[want.status]++;
			if (want.contained) contained_seen++;
			field_check("result_address", TOTAL_W'(want.addr), TOTAL_W'(got.addr));
			field_check("status", TOTAL_W'(want.status), TOTAL_W'(got.status));
			field_check("is_contained", TOTAL_W'(want.contained), TOTAL_W'(got.contained));
			field_check("current_bytes", TOTAL_W'(want.cur_bytes), TOTAL_W'(got.cur_bytes));
			field_check("peak_bytes", TOTAL_W'(want.peak), TOTAL_W'(got.peak));
			field_check("total_bytes", want.total, got.total);
			field_check("allocation_count", TOTAL_W'(want.allocs), TOTAL_W'(got.allocs));
			field_check("free_count", TOTAL_W'(want.frees), TOTAL_W'(got.frees));
		endfunction
	endclass

endpackage

/* tb/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: fixed block pool allocator
// Directed items on the reset geometry, then random traffic under several
// register settings: fill and drain cycles to the page limit and the top of
// the address space, stray and null frees, a free stack flood, and queries
// on region edges. Results are checked in order against a private model.
// ----------------------------------------------------------------------------
module testbench;
	import fbpa_pkg::*;
	import fbpa_tb_pkg::*;

	localparam int IDLE_LIMIT = 500;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  start, busy, done;
	logic [1:0]            command, status;
	logic [ADDR_W-1:0]     block_address, result_address;
	logic                  is_contained;
	logic [STAT_W-1:0]     current_bytes, peak_bytes, allocation_count, free_count;
	logic [TOTAL_W-1:0]    total_bytes;
	logic                  cfg_valid, cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	pool_scoreboard        sb;
	logic [ADDR_W-1:0]     live_blocks[$];
	int                    items_sent = 0;
	int                    cfg_writes = 0;
	int                    burst_left = 0;
	int                    idle_cycles = 0;
	bit                    filling = 1'b1;

	fixed_block_pool_allocator dut (.*);

	// 4 ns clock
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// result monitor
	always @(posedge clk) begin
		pool_result_t got;
		if (arst_n && done === 1'b1) begin
			got.addr = result_address;
			got.status = status;
			got.contained = is_contained;
			got.cur_bytes = current_bytes;
			got.peak = peak_bytes;
			got.total = total_bytes;
			got.allocs = allocation_count;
			got.frees = free_count;
			sb.check_result(got);
		end
	end

	// watchdog: too long without any handshake
	always @(posedge clk) begin
		if ((start && busy === 1'b0) || done === 1'b1 || (cfg_valid && cfg_ready === 1'b1))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("testbench: FAIL");
			$finish;
		end
	end

	// present one item, hold it until accepted; returns at the next falling edge
	task automatic send_item(cmd_t c, logic [ADDR_W-1:0] a);
		pool_result_t r;
		start <= 1'b1;
		command <= c;
		block_address <= a;
		do @(posedge clk); while (busy !== 1'b0);
		r = sb.predict_result(c, a);
		items_sent++;
		if (c == CMD_ALLOC && r.status == ST_OK) live_blocks = {live_blocks, r.addr};
		@(negedge clk);
	endtask

	// sender bursts: random length, random gap after each burst
	task automatic pace();
		int gap;
		if (burst_left > 0) begin
			burst_left--;
			return;
		end
		burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
		gap = $urandom_range(1, 6);
		start <= 1'b0;
		repeat (gap) @(negedge clk);
	endtask

	// cfg_valid is left high; the caller drops it after the last write
	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (cfg_ready !== 1'b1);
		sb.apply_reg(idx, data);
		cfg_writes++;
		@(negedge clk);
	endtask

	task automatic drain();
		start <= 1'b0;
		while (sb.expected_results.size() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic configure(logic [15:0] req, logic [12:0] align, logic [12:0] bpp,
			logic [31:0] base);
		drain();
		write_reg(CFG_REQ_SIZE, CFG_DATA_W'(req));
		write_reg(CFG_ALIGN, CFG_DATA_W'(align));
		write_reg(CFG_BPP, CFG_DATA_W'(bpp));
		write_reg(CFG_BASE, base);
		cfg_valid <= 1'b0;
		live_blocks.delete();
	endtask

	// query targets: live blocks, inside the region, just around its edges, random and null
	function automatic logic [ADDR_W-1:0] pick_query();
		longint unsigned lo, used;
		lo = sb.region_start;
		used = sb.region_used;
		case ($urandom_range(0, 6))
			0: return (live_blocks.size() > 0) ?
				live_blocks[$urandom_range(0, live_blocks.size() - 1)] : ADDR_W'(lo);
			1: return (used > 0) ? ADDR_W'(lo + longint'($urandom) % used) : ADDR_W'(lo);
			2: return ADDR_W'(lo - 1);
			3: return ADDR_W'(lo + used - 1);
			4: return ADDR_W'(lo + used);
			5: return $urandom;
			default: return '0;
		endcase
	endfunction

	// frees that are not a clean return of a live block
	function automatic logic [ADDR_W-1:0] pick_stray();
		case ($urandom_range(0, 4))
			0: return '0;
			1: return '1;
			2: return ADDR_W'(sb.region_start);
			3: return (live_blocks.size() > 0) ? live_blocks[$] : $urandom;
			default: return $urandom;
		endcase
	endfunction

	// random traffic; flood mode mostly frees to fill the free stack
	task automatic random_items(int n, bit flood);
		int r, k;
		cmd_t c;
		logic [ADDR_W-1:0] a;
		repeat (n) begin
			r = $urandom_range(0, 99);
			a = $urandom;
			if ($urandom_range(0, 29) == 0) filling = !filling;
			if (flood) begin
				if (r < 97) begin
					c = CMD_FREE;
					if (r == 0) a = '0;
				end else if (r < 99) begin
					c = CMD_ALLOC;
				end else begin
					c = CMD_QUERY;
					a = pick_query();
				end
			end else if (r < (filling ? 65 : 25)) begin
				c = CMD_ALLOC;
			end else if (r < 75 && live_blocks.size() > 0) begin
				k = $urandom_range(0, live_blocks.size() - 1);
				c = CMD_FREE;
				a = live_blocks[k];
				live_blocks.delete(k);
			end else if (r < 80) begin
				c = CMD_FREE;
				a = pick_stray();
			end else if (r < 95) begin
				c = CMD_QUERY;
				a = pick_query();
			end else begin
				c = CMD_NOP;
			end
			pace();
			send_item(c, a);
		end
	endtask

	initial begin
		sb = new();
		arst_n = 1'b0;
		start = 1'b0;
		command = CMD_ALLOC;
		block_address = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// reset geometry: 16-byte blocks, one per page, region at zero
		send_item(CMD_ALLOC, '0);            // first block lands on address zero
		send_item(CMD_FREE, '0);             // freeing it counts as a null free
		send_item(CMD_QUERY, '0);            // null query
		send_item(CMD_QUERY, 32'h0000_000F); // last byte of page one
		send_item(CMD_QUERY, 32'h0000_0010); // first byte past it
		send_item(CMD_NOP, '1);
		send_item(CMD_FREE, '1);             // unchecked free of a foreign address
		send_item(CMD_ALLOC, '0);            // pops it back
		send_item(CMD_FREE, 32'hAAAA_5555);
		repeat (17) send_item(CMD_ALLOC, '0); // pop, pages 2..16, then out of memory

		// align 0 -> 16, 32-byte blocks
		configure(16'd24, 13'd0, 13'd4, 32'h0000_1000);
		random_items(150, 1'b0);
		// odd alignment rounds to 128, unaligned base
		configure(16'd100, 13'd100, 13'd3, 32'h1234_5679);
		random_items(200, 1'b0);
		// largest fields; base rounds up past the top and wraps to zero
		configure(16'hFFFF, 13'h1FFF, 13'h1FFF, 32'hFFFF_FFFF);
		random_items(100, 1'b0);
		// zero blocks per page; only four pages fit below the top of the space
		configure(16'd4096, 13'd16, 13'd0, 32'hFFFF_C000);
		random_items(150, 1'b0);
		// free stack flood
		configure(16'd8, 13'd32, 13'd2, 32'h0004_0000);
		random_items(1120, 1'b1);
		// request below the minimum size
		configure(16'd0, 13'd1, 13'd5, 32'h8000_0000);
		random_items(150, 1'b0);
		configure(16'd3000, 13'd2048, 13'd16, 32'h7FFF_FFF0);
		random_items(100, 1'b0);

		drain();
		repeat (8) @(posedge clk);
		if (sb.expected_results.size() != 0) begin
			$error("%0d results never arrived", sb.expected_results.size());
			sb.errors++;
		end
		$display("summary: %0d items, %0d register writes, %0d results checked, %0d errors",
			items_sent, cfg_writes, sb.checked, sb.errors);
		$display("summary: ok/oom/full/null = %0d/%0d/%0d/%0d, %0d queries inside pages",
			sb.status_seen[ST_OK], sb.status_seen[ST_OOM], sb.status_seen[ST_FULL],
			sb.status_seen[ST_NULL], sb.contained_seen);
		if (sb.errors == 0)
			$display("testbench: PASS");
		else
			$display("testbench: FAIL");
		$finish;
	end

endmodule
